>>> rtl/owtr_pkg.sv
// owtr_pkg: constants and the command table of the 1-wire temperature reader
// no dependencies; used by one_wire_temperature_reader

package owtr_pkg;

    localparam int unsigned TIMER_W    = 10;
    localparam int unsigned CFG_IDX_W  = 2;
    localparam int unsigned CFG_DATA_W = 10;
    localparam int unsigned TEMP_W     = 17;
    localparam int unsigned S_DATA_W   = 8;
    localparam int unsigned M_DATA_W   = 24;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_RESET_LOW   = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_TEMP_OFFSET = 2'd1;

    localparam logic [CFG_DATA_W-1:0] RESET_LOW_DEFAULT   = 10'd750;
    localparam logic [CFG_DATA_W-1:0] TEMP_OFFSET_DEFAULT = 10'd48;

    // slot timings in microseconds
    localparam logic [TIMER_W-1:0] REL_AFTER_RESET = 10'd15;
    localparam logic [TIMER_W-1:0] W0_LOW          = 10'd70;
    localparam logic [TIMER_W-1:0] W0_TOTAL        = 10'd72;
    localparam logic [TIMER_W-1:0] W1_LOW          = 10'd9;
    localparam logic [TIMER_W-1:0] W1_TOTAL        = 10'd64;
    localparam logic [TIMER_W-1:0] RD_LOW          = 10'd15;
    localparam logic [TIMER_W-1:0] RD_TOTAL        = 10'd65;

    // sequence steps
    localparam logic [2:0] STEP_RESET1   = 3'd0;
    localparam logic [2:0] STEP_RESET2   = 3'd3;
    localparam logic [2:0] STEP_LAST_WR  = 3'd5;
    localparam logic [2:0] STEP_READ_LO  = 3'd6;
    localparam logic [2:0] STEP_READ_HI  = 3'd7;

    localparam logic [7:0] CMD_SKIP_ROM   = 8'hCC;
    localparam logic [7:0] CMD_CONVERT    = 8'h44;
    localparam logic [7:0] CMD_READ_SCRPD = 8'hBE;

    // command byte sent in each write step
    function automatic logic [7:0] step_cmd(input logic [2:0] step);
        logic [7:0] cmd;
        case (step)
            3'd1, 3'd4: cmd = CMD_SKIP_ROM;
            3'd2:       cmd = CMD_CONVERT;
            3'd5:       cmd = CMD_READ_SCRPD;
            default:    cmd = 8'h00;
        endcase
        return cmd;
    endfunction

endpackage

>>> rtl/one_wire_temperature_reader.sv
// one_wire_temperature_reader: 1-wire master that reads a temperature sensor
// depends on owtr_pkg
//
// usage:
//   s_* : one word per microsecond tick carrying the sampled line level and a
//         start request. every accepted word advances the sequencer by one tick.
//   m_* : one word per accepted tick with the line drive, busy and done flags,
//         the last temperature (raw minus offset, sixteenths of a degree) and
//         the presence failure flag.
//   cfg_*: register writes (index 0 reset low time, index 1 offset); always
//         ready, unknown indexes are dropped. write only while idle.
// a start request in idle runs reset, presence, skip rom, convert, reset,
// presence, skip rom, read scratchpad, then reads two bytes lsb first.
// output: the result word of a tick sits in the output register from the
// cycle after the tick is accepted. throughput: one tick per cycle unless
// stalled, set by the single registered pass of the sequencer state update.
// stall: while the output register holds an untaken word and m_tready is low,
// s_tready drops and the sequencer holds; no tick is lost.
// reset: sequencer idle, temperature 0, registers at their defaults, output
// register empty.

module one_wire_temperature_reader #(
    parameter int unsigned PRESENCE_WAIT_US = 100,
    parameter int unsigned PRESENCE_MAX_US  = 240
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // [0] line_in, [1] start_req, [7:2] zero
    input  logic [owtr_pkg::S_DATA_W-1:0]     s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // [0] drive_low, [1] busy_res, [2] done_res, [19:3] temperature,
    // [20] no_presence, [23:21] zero
    output logic [owtr_pkg::M_DATA_W-1:0]     m_tdata,
    input  logic                              cfg_valid,
    output logic                              cfg_ready,
    input  logic [owtr_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  logic [owtr_pkg::CFG_DATA_W-1:0]   cfg_data
);

    typedef enum logic [4:0] {
        PH_IDLE      = 5'd0,
        PH_RST_LOW   = 5'd1,
        PH_RST_REL   = 5'd2,
        PH_PRES_WAIT = 5'd3,
        PH_PRES_LOW  = 5'd4,
        PH_WRITE     = 5'd5,
        PH_READ      = 5'd6
    } phase_t;

    localparam logic [owtr_pkg::TIMER_W-1:0] WAIT_LIM =
        owtr_pkg::TIMER_W'(PRESENCE_WAIT_US);
    localparam logic [owtr_pkg::TIMER_W-1:0] MAX_LIM =
        owtr_pkg::TIMER_W'(PRESENCE_MAX_US);

    // configuration registers
    logic [owtr_pkg::CFG_DATA_W-1:0] reset_low_reg;
    logic [owtr_pkg::CFG_DATA_W-1:0] offset_reg;

    // sequencer state
    phase_t                          phase_reg,  phase_next;
    logic [owtr_pkg::TIMER_W-1:0]    timer_reg,  timer_next;
    logic [2:0]                      bit_reg,    bit_next;
    logic [2:0]                      step_reg,   step_next;
    logic [7:0]                      shift_reg,  shift_next;
    logic [7:0]                      low_reg,    low_next;
    logic [owtr_pkg::TEMP_W-1:0]     result_reg, result_next;
    logic                            pfail_reg,  pfail_next;

    // output register
    logic                            out_valid_reg;
    logic                            drive_reg, busy_reg, done_reg;
    logic                            drive_next, busy_next, done_next;

    logic line_in, start_req, accept;
    logic go_step, step_fail;
    logic [2:0] new_step;
    logic [7:0] cmd_byte;
    logic cmd_bit;
    logic [owtr_pkg::TIMER_W-1:0] low_len, total_len;
    logic signed [owtr_pkg::TEMP_W-1:0] raw_ext;

    assign line_in   = s_tdata[0];
    assign start_req = s_tdata[1];
    assign s_tready  = !out_valid_reg || m_tready;
    assign accept    = s_tvalid && s_tready;
    assign cfg_ready = 1'b1;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {3'b000, pfail_reg, result_reg, done_reg, busy_reg, drive_reg};

    always_comb
    begin
        phase_next  = phase_reg;
        timer_next  = timer_reg;
        bit_next    = bit_reg;
        step_next   = step_reg;
        shift_next  = shift_reg;
        low_next    = low_reg;
        result_next = result_reg;
        pfail_next  = pfail_reg;
        drive_next  = 1'b0;
        busy_next   = 1'b1;
        done_next   = 1'b0;
        go_step     = 1'b0;
        step_fail   = 1'b0;
        new_step    = step_reg + 3'd1;
        cmd_byte    = owtr_pkg::step_cmd(step_reg);
        cmd_bit     = cmd_byte[bit_reg];
        low_len     = cmd_bit ? owtr_pkg::W1_LOW : owtr_pkg::W0_LOW;
        total_len   = cmd_bit ? owtr_pkg::W1_TOTAL : owtr_pkg::W0_TOTAL;
        raw_ext     = '0;

        // start tick is already the first reset low tick
        if (phase_reg == PH_IDLE && start_req)
        begin
            pfail_next = 1'b0;
            step_next  = owtr_pkg::STEP_RESET1;
            timer_next = '0;
            bit_next   = '0;
            shift_next = '0;
            phase_next = PH_RST_LOW;
        end

        case (phase_next)
            PH_RST_LOW:
            begin
                drive_next = 1'b1;
                timer_next = timer_next + 1'b1;
                // a zero length still gives one low tick
                if (timer_next >= reset_low_reg || timer_next == '0)
                begin
                    phase_next = PH_RST_REL;
                    timer_next = '0;
                end
            end
            PH_RST_REL:
            begin
                timer_next = timer_next + 1'b1;
                if (timer_next >= owtr_pkg::REL_AFTER_RESET)
                begin
                    phase_next = PH_PRES_WAIT;
                    timer_next = '0;
                end
            end
            PH_PRES_WAIT:
            begin
                if (line_in)
                begin
                    timer_next = timer_next + 1'b1;
                    if (timer_next >= WAIT_LIM)
                    begin
                        go_step   = 1'b1;
                        step_fail = 1'b1;
                    end
                end
                else
                begin
                    phase_next = PH_PRES_LOW;
                    timer_next = owtr_pkg::TIMER_W'(1);
                    if (timer_next >= MAX_LIM)
                    begin
                        go_step   = 1'b1;
                        step_fail = 1'b1;
                    end
                end
            end
            PH_PRES_LOW:
            begin
                if (line_in)
                begin
                    go_step = 1'b1;
                end
                else
                begin
                    timer_next = timer_next + 1'b1;
                    if (timer_next >= MAX_LIM)
                    begin
                        go_step   = 1'b1;
                        step_fail = 1'b1;
                    end
                end
            end
            PH_WRITE:
            begin
                drive_next = timer_next < low_len;
                timer_next = timer_next + 1'b1;
                if (timer_next >= total_len)
                begin
                    timer_next = '0;
                    if (bit_next == 3'd7)
                        go_step = 1'b1;
                    else
                        bit_next = bit_next + 3'd1;
                end
            end
            PH_READ:
            begin
                drive_next = timer_next < owtr_pkg::RD_LOW;
                // sample on the first released tick
                if (timer_next == owtr_pkg::RD_LOW)
                    shift_next[bit_next] = line_in;
                timer_next = timer_next + 1'b1;
                if (timer_next >= owtr_pkg::RD_TOTAL)
                begin
                    timer_next = '0;
                    if (bit_next != 3'd7)
                    begin
                        bit_next = bit_next + 3'd1;
                    end
                    else if (step_next == owtr_pkg::STEP_READ_LO)
                    begin
                        low_next = shift_next;
                        go_step  = 1'b1;
                    end
                    else
                    begin
                        raw_ext     = owtr_pkg::TEMP_W'(signed'({shift_next, low_next}));
                        result_next = raw_ext -
                            signed'({{(owtr_pkg::TEMP_W-owtr_pkg::CFG_DATA_W){1'b0}},
                                     offset_reg});
                        done_next   = 1'b1;
                        phase_next  = PH_IDLE;
                        bit_next    = '0;
                        step_next   = '0;
                        shift_next  = '0;
                    end
                end
            end
            default:
            begin
                busy_next  = 1'b0;
                phase_next = PH_IDLE;
            end
        endcase

        // move on to the next step of the sequence
        if (go_step)
        begin
            pfail_next = pfail_next | step_fail;
            step_next  = new_step;
            timer_next = '0;
            bit_next   = '0;
            shift_next = '0;
            if (new_step == owtr_pkg::STEP_RESET1 || new_step == owtr_pkg::STEP_RESET2)
                phase_next = PH_RST_LOW;
            else if (new_step <= owtr_pkg::STEP_LAST_WR)
                phase_next = PH_WRITE;
            else
                phase_next = PH_READ;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reset_low_reg <= owtr_pkg::RESET_LOW_DEFAULT;
            offset_reg    <= owtr_pkg::TEMP_OFFSET_DEFAULT;
        end
        else if (cfg_valid && cfg_ready)
        begin
            unique case (cfg_index)
                owtr_pkg::CFG_RESET_LOW:   reset_low_reg <= cfg_data;
                owtr_pkg::CFG_TEMP_OFFSET: offset_reg    <= cfg_data;
                default: ;
            endcase
        end
    end

    // sequencer state and registered outputs
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg     <= PH_IDLE;
            timer_reg     <= '0;
            bit_reg       <= '0;
            step_reg      <= '0;
            shift_reg     <= '0;
            low_reg       <= '0;
            result_reg    <= '0;
            pfail_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            drive_reg     <= 1'b0;
            busy_reg      <= 1'b0;
            done_reg      <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                phase_reg  <= phase_next;
                timer_reg  <= timer_next;
                bit_reg    <= bit_next;
                step_reg   <= step_next;
                shift_reg  <= shift_next;
                low_reg    <= low_next;
                result_reg <= result_next;
                pfail_reg  <= pfail_next;
                drive_reg  <= drive_next;
                busy_reg   <= busy_next;
                done_reg   <= done_next;
            end
            if (accept)
                out_valid_reg <= 1'b1;
            else if (m_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // a finished read always lands back in idle
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && done_reg |-> busy_reg && phase_reg == PH_IDLE)
        else $error("done without idle return");

    // the bus is only pulled low inside a sequence
    a_drive_busy: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && drive_reg |-> busy_reg)
        else $error("line driven while not busy");

    // an empty output register never blocks the input
    a_ready_empty: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid_reg |-> s_tready)
        else $error("input stalled with empty output");

    // the sequencer holds while no tick is taken
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> $stable(phase_reg) && $stable(timer_reg))
        else $error("sequencer moved without a tick");

endmodule
